// ===== rtl/texture_axis_from_normal_macros.svh =====
// Assertion macros for the texture axis block.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef TEXTURE_AXIS_FROM_NORMAL_MACROS_SVH
`define TEXTURE_AXIS_FROM_NORMAL_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TAFN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TAFN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tafn_pkg.sv =====
// Shared constants for the texture axis block.
// No dependencies; used by the interfaces, the root lane, the top level, the checker and tb.
`timescale 1ns / 1ps

package tafn_pkg;

  localparam int DEF_COMPONENT_WIDTH = 16;
  localparam int OUT_W               = 16;
  localparam int THR_W               = 13;
  localparam int CFG_AW              = 3;
  localparam int CFG_DW              = 32;

  // Register map (index of each register)
  localparam logic REG_ZERO_THRESHOLD = 1'b0;
  localparam logic [THR_W-1:0] ZERO_THRESHOLD_RST = 13'd1;

  localparam logic signed [OUT_W-1:0] Q14_ONE = 16'sd16384;

  // Quotient floor(num * 2^30 / den) has 31 bits; its root has 16.
  localparam int DIV_STEPS  = 31;
  localparam int ROOT_STEPS = 16;
  localparam int ROOT_W     = 16;
  localparam int LANE_LAT   = DIV_STEPS + ROOT_STEPS;
  localparam int FRONT_LAT  = 5;

endpackage

// ===== rtl/tafn_if.sv =====
// Valid/ready channel interfaces for the texture axis block.
// Depends on tafn_pkg for the result width.
`timescale 1ns / 1ps

interface tafn_in_if
  import tafn_pkg::*;
#(
  parameter int COMPONENT_WIDTH = DEF_COMPONENT_WIDTH
);
  logic                              valid;
  logic                              ready;
  logic signed [COMPONENT_WIDTH-1:0] normal_x;
  logic signed [COMPONENT_WIDTH-1:0] normal_y;
  logic signed [COMPONENT_WIDTH-1:0] normal_z;

  modport source (output valid, normal_x, normal_y, normal_z, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, output ready);
endinterface

interface tafn_out_if
  import tafn_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] s_axis_x;
  logic signed [OUT_W-1:0] s_axis_y;
  logic signed [OUT_W-1:0] t_axis_x;
  logic signed [OUT_W-1:0] t_axis_y;
  logic signed [OUT_W-1:0] t_axis_z;

  modport source (output valid, s_axis_x, s_axis_y, t_axis_x, t_axis_y, t_axis_z,
                  input ready);
  modport sink   (input valid, s_axis_x, s_axis_y, t_axis_x, t_axis_y, t_axis_z,
                  output ready);
endinterface

// ===== rtl/tafn_root_lane.sv =====
// One pipelined lane: isqrt(floor(num * 2^30 / den)), num <= den.
// Restoring divider, one quotient bit per stage, then a restoring square root.
`timescale 1ns / 1ps

module tafn_root_lane
  import tafn_pkg::*;
#(
  parameter int DW = 2 * DEF_COMPONENT_WIDTH + 1
) (
  input  logic              clk,
  input  logic              adv,
  input  logic [DW-1:0]     num,
  input  logic [DW-1:0]     den,
  output logic [ROOT_W-1:0] root
);

  localparam int QW = DIV_STEPS;

  logic [DW-1:0] rem_r [DIV_STEPS];
  logic [DW-1:0] den_r [DIV_STEPS];
  logic [QW-1:0] quo_r [DIV_STEPS];

  logic [QW-1:0] op_r  [ROOT_STEPS];
  logic [QW:0]   res_r [ROOT_STEPS];

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    logic [DW:0]   part;
    logic [DW:0]   diff;
    logic [DW-1:0] dsrc;
    logic [QW-1:0] qsrc;
    logic          ge;
    logic [DW-1:0] rem_nxt;

    if (i == 0) begin : g_first
      assign part = {1'b0, num};
      assign dsrc = den;
      assign qsrc = '0;
    end else begin : g_next
      assign part = {rem_r[i-1], 1'b0};
      assign dsrc = den_r[i-1];
      assign qsrc = quo_r[i-1];
    end

    assign diff    = part - {1'b0, dsrc};
    assign ge      = (part >= {1'b0, dsrc});
    assign rem_nxt = ge ? diff[DW-1:0] : part[DW-1:0];

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[i] <= rem_nxt;
        den_r[i] <= dsrc;
        quo_r[i] <= {qsrc[QW-2:0], ge};
      end
    end
  end

  for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
    localparam logic [QW:0] ONE_BIT = (QW+1)'(1) << (2 * (ROOT_STEPS - 1 - j));
    logic [QW-1:0] op_in;
    logic [QW:0]   res_in;
    logic [QW:0]   trial;
    logic [QW:0]   left;
    logic          ge;
    logic [QW-1:0] op_nxt;
    logic [QW:0]   res_nxt;

    if (j == 0) begin : g_first
      assign op_in  = quo_r[DIV_STEPS-1];
      assign res_in = '0;
    end else begin : g_next
      assign op_in  = op_r[j-1];
      assign res_in = res_r[j-1];
    end

    assign trial   = res_in + ONE_BIT;
    assign ge      = ({1'b0, op_in} >= trial);
    assign left    = {1'b0, op_in} - trial;
    assign op_nxt  = ge ? left[QW-1:0] : op_in;
    assign res_nxt = ge ? ((res_in >> 1) + ONE_BIT) : (res_in >> 1);

    always_ff @(posedge clk) begin
      if (adv) begin
        op_r[j]  <= op_nxt;
        res_r[j] <= res_nxt;
      end
    end
  end

  assign root = res_r[ROOT_STEPS-1][ROOT_W-1:0];

endmodule

// ===== rtl/texture_axis_from_normal.sv =====
// Top level of the texture axis block: config register, front stages, five root lanes.
// Depends on tafn_pkg, tafn_if.sv, tafn_root_lane and the assertion macro header.
//
//   channel  | role   | handshake          | word
//   in_if    | sink   | valid/ready        | normal_x, normal_y, normal_z
//   out_if   | source | valid/ready        | s_axis_x/y, t_axis_x/y/z
//   apb      | slave  | psel/penable/pready| zero_threshold at byte address 0
//
// One word accepted per cycle while no word is parked in the skid register; the path from accept
// to out valid is 5 front stages, 31 divider stages, 16 square root stages and the output register.
// The divider and root lanes set the depth; every front and lane stage shares one advance enable.
// Synchronous active-low reset clears valids and sets zero_threshold to 1.
// A stalled output parks one word in a skid register; input ready drops only then.
`timescale 1ns / 1ps
`include "texture_axis_from_normal_macros.svh"

module texture_axis_from_normal
  import tafn_pkg::*;
#(
  parameter int COMPONENT_WIDTH = DEF_COMPONENT_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  tafn_in_if.sink           in_if,
  tafn_out_if.source        out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int W        = COMPONENT_WIDTH;
  localparam int SQ_W     = 2 * W;
  localparam int R2_W     = 2 * W + 1;
  localparam int M2_W     = 2 * W + 2;
  localparam int HALF     = W + 1;
  localparam int PP_W     = 3 * W + 2;
  localparam int ZX_W     = 4 * W;
  localparam int RM_W     = 4 * W + 3;
  localparam int CMP_W    = (W > THR_W) ? W : THR_W;
  localparam int PIPE_LAT = FRONT_LAT + LANE_LAT;

  typedef struct packed {
    logic sx_neg;
    logic sy_neg;
    logic tx_neg;
    logic ty_neg;
    logic r_zero;
    logic z_nz;
    logic z_neg;
  } sb_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] s_x;
    logic signed [OUT_W-1:0] s_y;
    logic signed [OUT_W-1:0] t_x;
    logic signed [OUT_W-1:0] t_y;
    logic signed [OUT_W-1:0] t_z;
  } res_t;

  // ---------------- configuration ----------------
  logic [THR_W-1:0] zt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zt_r <= ZERO_THRESHOLD_RST;
    end else if (psel && penable && pwrite && (paddr[2] == REG_ZERO_THRESHOLD)) begin
      zt_r <= pwdata[THR_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ZERO_THRESHOLD) ? CFG_DW'(zt_r) : '0;

  // ---------------- flow control ----------------
  logic adv;
  logic out_v_r;
  logic skid_v_r;
  res_t out_r;
  res_t skid_r;
  logic [PIPE_LAT-1:0] pv_r;
  sb_t  psb_r [PIPE_LAT];

  assign adv         = !skid_v_r;
  assign in_if.ready = adv;

  // ---------------- cleaning ----------------
  function automatic logic [W:0] clean_f(logic [W-1:0] raw, logic [THR_W-1:0] thr);
    logic         neg;
    logic [W-1:0] mag;
    logic [W:0]   res;
    neg = raw[W-1];
    mag = neg ? (~raw + 1'b1) : raw;
    if (CMP_W'(mag) < CMP_W'(thr)) begin
      res = '0;
    end else begin
      res = {neg, mag};
    end
    return res;
  endfunction

  logic [W:0] cx, cy, cz;
  sb_t        sb_in;

  always_comb begin
    cx = clean_f(in_if.normal_x, zt_r);
    cy = clean_f(in_if.normal_y, zt_r);
    cz = clean_f(in_if.normal_z, zt_r);
    sb_in.sx_neg = !cy[W] && (cy[W-1:0] != '0);
    sb_in.sy_neg = cx[W];
    sb_in.tx_neg = (cz[W] != cx[W]) && (cz[W-1:0] != '0) && (cx[W-1:0] != '0);
    sb_in.ty_neg = (cz[W] != cy[W]) && (cz[W-1:0] != '0) && (cy[W-1:0] != '0);
    sb_in.r_zero = (cx[W-1:0] == '0) && (cy[W-1:0] == '0);
    sb_in.z_nz   = (cz[W-1:0] != '0);
    sb_in.z_neg  = cz[W];
  end

  // ---------------- front stages ----------------
  logic [W-1:0]    ax_r, ay_r, az_r;
  logic [SQ_W-1:0] x2_r, y2_r, z2_r;
  logic [SQ_W-1:0] x2b_r, y2b_r, z2b_r;
  logic [R2_W-1:0] r2_r;
  logic [M2_W-1:0] m2_r;
  logic [SQ_W-1:0] x2c_r, y2c_r;
  logic [R2_W-1:0] r2c_r;
  logic [M2_W-1:0] m2c_r;
  logic [ZX_W-1:0] zx_r, zy_r;
  logic [PP_W-1:0] rml_r, rmh_r;
  logic [SQ_W-1:0] x2d_r, y2d_r;
  logic [R2_W-1:0] r2d_r;
  logic [M2_W-1:0] m2d_r;
  logic [ZX_W-1:0] zxd_r, zyd_r;
  logic [RM_W-1:0] rm_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ax_r  <= cx[W-1:0];
      ay_r  <= cy[W-1:0];
      az_r  <= cz[W-1:0];
      // squares
      x2_r  <= SQ_W'(ax_r) * SQ_W'(ax_r);
      y2_r  <= SQ_W'(ay_r) * SQ_W'(ay_r);
      z2_r  <= SQ_W'(az_r) * SQ_W'(az_r);
      // sums of squares
      x2b_r <= x2_r;
      y2b_r <= y2_r;
      z2b_r <= z2_r;
      r2_r  <= R2_W'(x2_r) + R2_W'(y2_r);
      m2_r  <= M2_W'(x2_r) + M2_W'(y2_r) + M2_W'(z2_r);
      // products, r2*m2 split in two partial products
      x2c_r <= x2b_r;
      y2c_r <= y2b_r;
      r2c_r <= r2_r;
      m2c_r <= m2_r;
      zx_r  <= ZX_W'(z2b_r) * ZX_W'(x2b_r);
      zy_r  <= ZX_W'(z2b_r) * ZX_W'(y2b_r);
      rml_r <= PP_W'(r2_r) * PP_W'(m2_r[HALF-1:0]);
      rmh_r <= PP_W'(r2_r) * PP_W'(m2_r[M2_W-1:HALF]);
      // combine partial products
      x2d_r <= x2c_r;
      y2d_r <= y2c_r;
      r2d_r <= r2c_r;
      m2d_r <= m2c_r;
      zxd_r <= zx_r;
      zyd_r <= zy_r;
      rm_r  <= RM_W'(rml_r) + (RM_W'(rmh_r) << HALF);
    end
  end

  // valid and sideband line, same depth as the data path
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else if (adv) begin
      pv_r <= {pv_r[PIPE_LAT-2:0], in_if.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      psb_r[0] <= sb_in;
      for (int k = 1; k < PIPE_LAT; k++) begin
        psb_r[k] <= psb_r[k-1];
      end
    end
  end

  // ---------------- root lanes ----------------
  logic [ROOT_W-1:0] sx_root, sy_root, tx_root, ty_root, tz_root;

  tafn_root_lane #(.DW(R2_W)) u_lane_sx (
    .clk(clk), .adv(adv), .num(R2_W'(y2d_r)), .den(r2d_r), .root(sx_root)
  );
  tafn_root_lane #(.DW(R2_W)) u_lane_sy (
    .clk(clk), .adv(adv), .num(R2_W'(x2d_r)), .den(r2d_r), .root(sy_root)
  );
  tafn_root_lane #(.DW(RM_W)) u_lane_tx (
    .clk(clk), .adv(adv), .num(RM_W'(zxd_r)), .den(rm_r), .root(tx_root)
  );
  tafn_root_lane #(.DW(RM_W)) u_lane_ty (
    .clk(clk), .adv(adv), .num(RM_W'(zyd_r)), .den(rm_r), .root(ty_root)
  );
  tafn_root_lane #(.DW(M2_W)) u_lane_tz (
    .clk(clk), .adv(adv), .num(M2_W'(r2d_r)), .den(m2d_r), .root(tz_root)
  );

  // ---------------- rounding and packing ----------------
  // nearest Q1.14 step: q = (isqrt + 1) / 2
  function automatic logic signed [OUT_W-1:0] pack_f(logic [ROOT_W-1:0] rt, logic neg);
    logic [ROOT_W:0]  sum;
    logic [OUT_W-1:0] q;
    sum = {1'b0, rt} + (ROOT_W+1)'(1);
    q   = sum[OUT_W:1];
    return neg ? $signed(-q) : $signed(q);
  endfunction

  logic tail_v;
  sb_t  tail_sb;
  res_t tail;

  assign tail_v  = pv_r[PIPE_LAT-1];
  assign tail_sb = psb_r[PIPE_LAT-1];

  always_comb begin
    if (tail_sb.r_zero) begin
      tail.s_x = '0;
      tail.s_y = Q14_ONE;
      if (tail_sb.z_nz) begin
        tail.t_x = tail_sb.z_neg ? -Q14_ONE : Q14_ONE;
        tail.t_y = '0;
        tail.t_z = '0;
      end else begin
        tail.t_x = '0;
        tail.t_y = '0;
        tail.t_z = -Q14_ONE;
      end
    end else begin
      tail.s_x = pack_f(sx_root, tail_sb.sx_neg);
      tail.s_y = pack_f(sy_root, tail_sb.sy_neg);
      tail.t_x = pack_f(tx_root, tail_sb.tx_neg);
      tail.t_y = pack_f(ty_root, tail_sb.ty_neg);
      tail.t_z = pack_f(tz_root, 1'b1);
    end
  end

  // ---------------- output register and skid ----------------
  logic out_free;
  assign out_free = !out_v_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= adv && tail_v;
      end
    end else if (adv && tail_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_v_r ? skid_r : tail;
    end else if (adv && tail_v) begin
      // park the word while the output is held
      skid_r <= tail;
    end
  end

  assign out_if.valid    = out_v_r;
  assign out_if.s_axis_x = out_r.s_x;
  assign out_if.s_axis_y = out_r.s_y;
  assign out_if.t_axis_x = out_r.t_x;
  assign out_if.t_axis_y = out_r.t_y;
  assign out_if.t_axis_z = out_r.t_z;

  // ---------------- assertions ----------------
  `TAFN_ASSERT_NOW(a_skid_behind_out, skid_v_r, out_v_r, "skid word without output word")
  `TAFN_ASSERT_NEXT(a_skid_fill, adv && tail_v && out_v_r && !out_if.ready, skid_v_r, "stalled word not parked")
  `TAFN_ASSERT_NOW(a_tz_nonpos, out_v_r, !(out_r.t_z > 0), "t_axis_z positive")
  `TAFN_ASSERT_NOW(a_s_nonzero, out_v_r, (out_r.s_x != '0) || (out_r.s_y != '0), "first axis is zero")

endmodule

// ===== test/tafn_checker.sv =====
// Checker for the texture axis block: predicts both axes for every accepted normal
// and compares each output word in order. Depends on tafn_pkg and tafn_if.sv.
`timescale 1ns / 1ps

module tafn_checker
  import tafn_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  tafn_in_if                in_m,
  tafn_out_if               out_m,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output int                err_count,
  output int                pending,
  output int                axes_seen
);

  typedef struct packed {
    logic signed [OUT_W-1:0] s_x;
    logic signed [OUT_W-1:0] s_y;
    logic signed [OUT_W-1:0] t_x;
    logic signed [OUT_W-1:0] t_y;
    logic signed [OUT_W-1:0] t_z;
  } axes_t;

  axes_t           axes_q[$];
  logic [THR_W-1:0] thr;

  // round(16384 * sqrt(num / den)), halves away from zero, by comparing squares
  function automatic logic [15:0] root_q14(logic [127:0] num, logic [127:0] den);
    logic [127:0] rhs;
    logic [127:0] odd;
    int lo;
    int hi;
    int mid;
    rhs = num << 30;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      odd = 128'(2 * mid - 1);
      if (odd * odd * den <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return 16'(lo);
  endfunction

  function automatic logic [15:0] signed_q14(logic [15:0] mag, bit neg);
    return neg ? 16'(-mag) : mag;
  endfunction

  function automatic logic [16:0] cleaned_mag(logic [15:0] raw, logic [THR_W-1:0] limit,
                                              output bit neg);
    logic [16:0] mag;
    neg = raw[15];
    mag = neg ? 17'h10000 - {1'b0, raw} : {1'b0, raw};
    if (mag < limit) begin
      mag = '0;
      neg = 0;
    end
    return mag;
  endfunction

  function automatic axes_t predict_axes(logic [15:0] nx_in, logic [15:0] ny_in,
                                         logic [15:0] nz_in, logic [THR_W-1:0] limit);
    axes_t a;
    bit nx, ny, nz;
    logic [127:0] ax, ay, az, x2, y2, z2, r2, m2;
    ax = 128'(cleaned_mag(nx_in, limit, nx));
    ay = 128'(cleaned_mag(ny_in, limit, ny));
    az = 128'(cleaned_mag(nz_in, limit, nz));
    x2 = ax * ax;
    y2 = ay * ay;
    z2 = az * az;
    r2 = x2 + y2;
    m2 = r2 + z2;
    if (r2 == 0) begin
      a.s_x = '0;
      a.s_y = Q14_ONE;
      a.t_y = '0;
      if (az != 0) begin
        a.t_x = signed_q14(Q14_ONE, nz);
        a.t_z = '0;
      end else begin
        a.t_x = '0;
        a.t_z = -Q14_ONE;
      end
    end else begin
      a.s_x = signed_q14(root_q14(y2, r2), !ny && ay != 0);
      a.s_y = signed_q14(root_q14(x2, r2), nx);
      a.t_x = signed_q14(root_q14(z2 * x2, r2 * m2), (nz != nx) && az != 0 && ax != 0);
      a.t_y = signed_q14(root_q14(z2 * y2, r2 * m2), (nz != ny) && az != 0 && ay != 0);
      a.t_z = signed_q14(root_q14(r2, m2), 1);
    end
    return a;
  endfunction

  assign pending = axes_q.size();

  always @(posedge clk) begin
    axes_t want;
    axes_t got;
    if (!rst_n) begin
      thr <= ZERO_THRESHOLD_RST;
      err_count <= 0;
      axes_seen <= 0;
      axes_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == {REG_ZERO_THRESHOLD, 2'b00})
        thr <= pwdata[THR_W-1:0];
      if (in_m.valid && in_m.ready)
        axes_q.push_back(predict_axes(in_m.normal_x, in_m.normal_y, in_m.normal_z, thr));
      if (out_m.valid && out_m.ready) begin
        got = '{out_m.s_axis_x, out_m.s_axis_y, out_m.t_axis_x, out_m.t_axis_y,
                out_m.t_axis_z};
        axes_seen <= axes_seen + 1;
        if (axes_q.size() == 0) begin
          if (err_count < 10) $display("unexpected output word %p", got);
          err_count <= err_count + 1;
        end else begin
          want = axes_q.pop_front();
          if (want != got) begin
            if (err_count < 10)
              $display("axes mismatch: expected s=(%0d,%0d) t=(%0d,%0d,%0d), got s=(%0d,%0d) t=(%0d,%0d,%0d)",
                       want.s_x, want.s_y, want.t_x, want.t_y, want.t_z,
                       got.s_x, got.s_y, got.t_x, got.t_y, got.t_z);
            err_count <= err_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== test/tb.sv =====
// Top of the texture axis testbench: clock, reset, normals, APB writes and verdict.
// Depends on tafn_pkg, tafn_if.sv, tafn_checker and texture_axis_from_normal.
`timescale 1ns / 1ps

module tb;
  import tafn_pkg::*;

  localparam int DRAIN_CYCLES = 64;
  localparam logic [CFG_AW-1:0] UNMAPPED_ADDR = 3'd4;

  logic clk = 0;
  logic rst_n = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;
  int err_count, pending, axes_seen;
  int idle_mode = 0;   // 0 none, 1 sender idles, 2 receiver stalls, 3 both
  int cur_thr = 1;
  int sent = 0;

  tafn_in_if  #(.COMPONENT_WIDTH(16)) in_bus ();
  tafn_out_if out_bus ();

  texture_axis_from_normal u_dut (
    .clk, .rst_n, .in_if(in_bus), .out_if(out_bus),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  tafn_checker u_chk (
    .clk, .rst_n, .in_m(in_bus), .out_m(out_bus),
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .err_count, .pending, .axes_seen
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    in_bus.valid = 0;
    in_bus.normal_x = '0;
    in_bus.normal_y = '0;
    in_bus.normal_z = '0;
    out_bus.ready = 0;
  end

  // idle percentage: 87 when one side idles, 16 when both do
  function automatic int idle_pct();
    return (idle_mode == 3) ? 16 : 87;
  endfunction

  always @(posedge clk) begin
    if (idle_mode == 2 || idle_mode == 3) out_bus.ready <= ($urandom_range(0, 99) >= idle_pct());
    else out_bus.ready <= 1'b1;
  end

  task automatic apb_write(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  // Drop valid, hold until the pipe is empty, then let the deepest stage settle.
  task automatic drain();
    in_bus.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_threshold(int value);
    drain();
    apb_write({REG_ZERO_THRESHOLD, 2'b00}, CFG_DW'(value));
    cur_thr = value & 13'h1fff;
  endtask

  task automatic send_normal(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    if (idle_mode == 1 || idle_mode == 3) begin
      while ($urandom_range(0, 99) < idle_pct()) begin
        in_bus.valid <= 0;
        @(posedge clk);
      end
    end
    in_bus.valid <= 1;
    in_bus.normal_x <= x;
    in_bus.normal_y <= y;
    in_bus.normal_z <= z;
    do @(posedge clk); while (!in_bus.ready);
    sent++;
  endtask

  function automatic logic [15:0] rand_component();
    int lim;
    lim = cur_thr + 2;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return $urandom_range(0, 1) ? 16'($urandom_range(0, lim)) : 16'(-$urandom_range(0, lim));
      2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      3: return 16'($urandom_range(0, 255)) - 16'd128;
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    int thr_plan[8];
    thr_plan = '{1, 0, 4096, 8191, 37, 2, 4095, 300};
    repeat (4) @(posedge clk);
    rst_n <= 1;

    // directed: axes, extremes, degenerate normals, cleaning edge
    send_normal(16'h0000, 16'h0000, 16'h4000);
    send_normal(16'h0000, 16'h0000, 16'hc000);
    send_normal(16'h0000, 16'h0000, 16'h0000);
    send_normal(16'h4000, 16'h0000, 16'h0000);
    send_normal(16'h0000, 16'h4000, 16'h0000);
    send_normal(16'h8000, 16'h8000, 16'h8000);
    send_normal(16'h7fff, 16'h7fff, 16'h7fff);
    send_normal(16'h8000, 16'h7fff, 16'h0001);
    send_normal(16'hffff, 16'h0001, 16'hffff);
    send_normal(16'h2d41, 16'hd2bf, 16'h0000);
    send_normal(16'h2000, 16'h2000, 16'h2d41);
    send_normal(16'hd2bf, 16'h2000, 16'hc000);
    send_normal(16'h0001, 16'h0000, 16'h8000);
    set_threshold(4096);
    send_normal(16'h0fff, 16'hf001, 16'h1000);
    send_normal(16'h1000, 16'hf000, 16'h0fff);
    send_normal(16'h0fff, 16'h0fff, 16'hf001);
    set_threshold(8191);
    send_normal(16'h1ffe, 16'h1fff, 16'he001);
    send_normal(16'h8000, 16'he002, 16'h1ffe);
    drain();
    apb_write(UNMAPPED_ADDR, 32'h0000_0005);
    send_normal(16'h0005, 16'h1fff, 16'h0000);

    for (int ph = 0; ph < 8; ph++) begin
      set_threshold(thr_plan[ph]);
      idle_mode = ph % 4;
      for (int i = 0; i < 204; i++) begin
        if (ph == 2 && i == 100) begin
          drain();
        end
        send_normal(rand_component(), rand_component(), rand_component());
      end
    end
    drain();

    $display("sent %0d normals over 8 threshold settings and 4 idle patterns,", sent);
    $display("%0d output words checked", axes_seen);
    if (err_count == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tafn_pkg.sv
rtl/tafn_if.sv
rtl/tafn_root_lane.sv
rtl/texture_axis_from_normal.sv
test/tafn_checker.sv
test/tb.sv
